// ===== rtl/mecanum_wheel_speed_mixer_macros.svh =====
// ---------------------------------------------------------------------------
// Mecanum wheel speed mixer: assertion macros
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef MECANUM_WHEEL_SPEED_MIXER_MACROS_SVH
`define MECANUM_WHEEL_SPEED_MIXER_MACROS_SVH

// same-cycle implication
`define MWSM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MWSM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mwsm_pkg.sv =====
// ---------------------------------------------------------------------------
// mwsm_pkg
// Widths, stage map, register codes and reset values of the wheel mixer.
// ---------------------------------------------------------------------------
package mwsm_pkg;

  localparam int NUM_WHEELS = 4;

  // field widths
  localparam int VEL_W       = 16;
  localparam int RPM_W       = 15;
  localparam int MASK_W      = 8;
  localparam int RADIUS_W    = 10;
  localparam int GAIN_W      = 16;
  localparam int MAXRPM_W    = 14;
  localparam int IN_TDATA_W  = 3 * VEL_W;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;

  // datapath widths
  localparam int YAW_FRAC = 10;                 // yaw rate in 1/1024 rad/s
  localparam int Q_SHIFT  = 26;                 // rpm accumulator: 2^-26 RPM
  localparam int SUM_W    = VEL_W + 1;          // vx +/- vy
  localparam int ROT_W    = 26;                 // yaw * radius
  localparam int VQ_W     = 28;                 // wheel speed, 1/1024 mm/s
  localparam int RPMQ_W   = 44;                 // signed wheel rpm, Q26
  localparam int MAG_W    = RPMQ_W - 1;
  localparam int NUM_W    = MAG_W + MAXRPM_W;   // |rpm| * max_rpm

  // quotient <= max_rpm, so one stage per bit of max_rpm
  localparam int DIV_STAGES = MAXRPM_W;

  // pipeline stage map
  localparam int ST_IN   = 0;
  localparam int ST_VQ   = 1;
  localparam int ST_RPM  = 2;
  localparam int ST_MAG  = 3;
  localparam int ST_PAIR = 4;
  localparam int ST_MAX  = 5;
  localparam int ST_DIV0 = 6;
  localparam int ST_OUT  = ST_DIV0 + DIV_STAGES;
  localparam int NSTG    = ST_OUT + 1;

  // register reset values
  localparam logic [MASK_W-1:0]   SIGN_MASK_RST  = MASK_W'(58);
  localparam logic [RADIUS_W-1:0] ROT_RADIUS_RST = RADIUS_W'(180);
  localparam logic [GAIN_W-1:0]   RPM_GAIN_RST   = GAIN_W'(16384);
  localparam logic [MAXRPM_W-1:0] MAX_RPM_RST    = MAXRPM_W'(200);

  typedef enum logic [1:0] {
    REG_SIGN_MASK  = 2'd0,
    REG_ROT_RADIUS = 2'd1,
    REG_RPM_GAIN   = 2'd2,
    REG_MAX_RPM    = 2'd3
  } cfg_reg_t;

  // what travels alongside the dividers
  typedef struct packed {
    logic                                 scale;
    logic [NUM_WHEELS-1:0]                neg;
    logic [NUM_WHEELS-1:0][MAXRPM_W-1:0]  unscaled;
  } side_t;

endpackage

// ===== rtl/mecanum_wheel_speed_mixer.sv =====
// ---------------------------------------------------------------------------
// mecanum_wheel_speed_mixer
// Four-wheel mecanum inverse kinematics: body velocity in, wheel RPM out,
// scaled down as a set when the fastest wheel would exceed max_rpm.
// ---------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in_     | slave     | in_tvalid/in_tready   | vel_forward, vel_lateral, yaw_rate
//  out_    | master    | out_tvalid/out_tready | four wheel RPM values, 15 b each
//  cfg_    | APB slave | psel/penable, pready  | sign_mask, rotation_radius_mm,
//          |           |                       | rpm_gain, max_rpm
//
//  One item per cycle sustained while out_tready stays high.
//  Most of the pipeline is the 14-stage restoring divider (one quotient bit a
//  stage) that forms max_rpm * |rpm| / largest for the scaled case.
//  Reset clears the stage valid bits and loads the register defaults.
//  Each stage holds only while it and every stage after it are full and
//  out_tready is low; bubbles close up under a stall.
// ---------------------------------------------------------------------------
module mecanum_wheel_speed_mixer import mwsm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // vel_forward [15:0], vel_lateral [31:16], yaw_rate [47:32]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // rpm_rear_left [14:0], rpm_front_left [29:15], rpm_front_right [44:30],
  // rpm_rear_right [59:45], zeros [63:60]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  // ------------------------------------------------------------ registers
  logic [MASK_W-1:0]   sign_mask_r,  sign_mask_nxt;
  logic [RADIUS_W-1:0] rot_radius_r, rot_radius_nxt;
  logic [GAIN_W-1:0]   rpm_gain_r,   rpm_gain_nxt;
  logic [MAXRPM_W-1:0] max_rpm_r,    max_rpm_nxt;
  logic                cfg_wr;
  cfg_reg_t            cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_sel    = cfg_reg_t'(cfg_paddr[3:2]);

  always_comb begin
    sign_mask_nxt  = sign_mask_r;
    rot_radius_nxt = rot_radius_r;
    rpm_gain_nxt   = rpm_gain_r;
    max_rpm_nxt    = max_rpm_r;
    if (cfg_wr) begin
      case (cfg_sel)
        REG_SIGN_MASK:  sign_mask_nxt  = cfg_pwdata[MASK_W-1:0];
        REG_ROT_RADIUS: rot_radius_nxt = cfg_pwdata[RADIUS_W-1:0];
        REG_RPM_GAIN:   rpm_gain_nxt   = cfg_pwdata[GAIN_W-1:0];
        REG_MAX_RPM:    max_rpm_nxt    = cfg_pwdata[MAXRPM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sign_mask_r  <= SIGN_MASK_RST;
      rot_radius_r <= ROT_RADIUS_RST;
      rpm_gain_r   <= RPM_GAIN_RST;
      max_rpm_r    <= MAX_RPM_RST;
    end else begin
      sign_mask_r  <= sign_mask_nxt;
      rot_radius_r <= rot_radius_nxt;
      rpm_gain_r   <= rpm_gain_nxt;
      max_rpm_r    <= max_rpm_nxt;
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_SIGN_MASK:  cfg_prdata = CFG_DATA_W'(sign_mask_r);
      REG_ROT_RADIUS: cfg_prdata = CFG_DATA_W'(rot_radius_r);
      REG_RPM_GAIN:   cfg_prdata = CFG_DATA_W'(rpm_gain_r);
      REG_MAX_RPM:    cfg_prdata = CFG_DATA_W'(max_rpm_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // ------------------------------------------------------------ flow control
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] en;

  // a stage may load when any stage from it onwards is empty, or out drains
  always_comb begin
    for (int k = 0; k < NSTG; k++) begin
      en[k] = out_tready || ((~vld_r & ~((NSTG'(1) << k) - NSTG'(1))) != '0);
    end
  end

  assign in_tready  = en[ST_IN];
  assign out_tvalid = vld_r[ST_OUT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[ST_IN]) vld_r[ST_IN] <= in_tvalid;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // ------------------------------------------------------------ stage IN
  logic signed [VEL_W-1:0]      vx, vy, wr;
  logic signed [VEL_W+RADIUS_W:0] rot_full;
  logic signed [SUM_W-1:0]      sum_p_r, sum_m_r;
  logic signed [ROT_W-1:0]      rot_r;

  assign vx = in_tdata[VEL_W-1:0];
  assign vy = in_tdata[2*VEL_W-1:VEL_W];
  assign wr = in_tdata[3*VEL_W-1:2*VEL_W];
  assign rot_full = wr * $signed({1'b0, rot_radius_r});

  always_ff @(posedge clk) begin
    if (en[ST_IN]) begin
      sum_p_r <= {vx[VEL_W-1], vx} + {vy[VEL_W-1], vy};
      sum_m_r <= {vx[VEL_W-1], vx} - {vy[VEL_W-1], vy};
      rot_r   <= rot_full[ROT_W-1:0];
    end
  end

  // ------------------------------------------------------------ per wheel
  logic signed [VQ_W-1:0]   vq_r    [NUM_WHEELS];
  logic signed [RPMQ_W-1:0] rpm_r   [NUM_WHEELS];
  logic [MAG_W-1:0]         mag_r   [NUM_WHEELS];
  logic [NUM_WHEELS-1:0]    neg3_r, neg4_r;
  logic [NUM_W-1:0]         num4_r  [NUM_WHEELS];
  logic [NUM_W-1:0]         num5_r  [NUM_WHEELS];
  logic [MAXRPM_W-1:0]      unsc4_r [NUM_WHEELS];
  logic [MAXRPM_W-1:0]      quo     [NUM_WHEELS];

  for (genvar i = 0; i < NUM_WHEELS; i++) begin : g_wheel
    logic signed [SUM_W-1:0]    lat;
    logic signed [VQ_W-1:0]     base, rotx, vq;
    logic signed [VQ_W+GAIN_W:0] rpm_full;
    logic [RPMQ_W-1:0]          absv;
    logic [NUM_W-1:0]           num_full;

    // stage VQ: (vx +/- vy) * 1024 +/- rot
    assign lat  = sign_mask_r[i] ? sum_m_r : sum_p_r;
    assign base = {lat[SUM_W-1], lat, {YAW_FRAC{1'b0}}};
    assign rotx = {{(VQ_W-ROT_W){rot_r[ROT_W-1]}}, rot_r};
    assign vq   = sign_mask_r[i+NUM_WHEELS] ? (base - rotx) : (base + rotx);

    // stage RPM
    assign rpm_full = vq_r[i] * $signed({1'b0, rpm_gain_r});

    // stage MAG
    assign absv = rpm_r[i][RPMQ_W-1] ? (~rpm_r[i] + RPMQ_W'(1)) : rpm_r[i];

    // stage PAIR
    assign num_full = mag_r[i] * max_rpm_r;

    always_ff @(posedge clk) begin
      if (en[ST_VQ])   vq_r[i]  <= vq;
      if (en[ST_RPM])  rpm_r[i] <= rpm_full[RPMQ_W-1:0];
      if (en[ST_MAG]) begin
        mag_r[i]  <= absv[MAG_W-1:0];
        neg3_r[i] <= rpm_r[i][RPMQ_W-1];
      end
      if (en[ST_PAIR]) begin
        num4_r[i]  <= num_full;
        unsc4_r[i] <= mag_r[i][Q_SHIFT +: MAXRPM_W];
        neg4_r[i]  <= neg3_r[i];
      end
      if (en[ST_MAX])  num5_r[i] <= num4_r[i];
    end
  end

  // ------------------------------------------------------------ largest wheel
  logic [MAG_W-1:0] pmax_r [2];
  logic [MAG_W-1:0] max_full, limit;
  logic [MAG_W-1:0] den_r;
  side_t            side5_r;
  side_t            side_r [DIV_STAGES];

  assign max_full = (pmax_r[0] > pmax_r[1]) ? pmax_r[0] : pmax_r[1];
  assign limit    = MAG_W'({max_rpm_r, {Q_SHIFT{1'b0}}});

  always_ff @(posedge clk) begin
    if (en[ST_PAIR]) begin
      pmax_r[0] <= (mag_r[0] > mag_r[1]) ? mag_r[0] : mag_r[1];
      pmax_r[1] <= (mag_r[2] > mag_r[3]) ? mag_r[2] : mag_r[3];
    end
    if (en[ST_MAX]) begin
      den_r         <= max_full;
      side5_r.scale <= max_full > limit;  // strict: at the limit passes through
      side5_r.neg   <= neg4_r;
      for (int w = 0; w < NUM_WHEELS; w++) begin
        side5_r.unscaled[w] <= unsc4_r[w];
      end
    end
  end

  // ------------------------------------------------------------ dividers
  for (genvar i = 0; i < NUM_WHEELS; i++) begin : g_div
    mwsm_divider u_div (
      .clk      (clk),
      .stage_en (en[ST_DIV0 +: DIV_STAGES]),
      .num_i    (num5_r[i]),
      .den_i    (den_r),
      .quo_o    (quo[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en[ST_DIV0]) side_r[0] <= side5_r;
    for (int j = 1; j < DIV_STAGES; j++) begin
      if (en[ST_DIV0+j]) side_r[j] <= side_r[j-1];
    end
  end

  // ------------------------------------------------------------ output
  logic [RPM_W-1:0] rpm_out_r [NUM_WHEELS];

  for (genvar i = 0; i < NUM_WHEELS; i++) begin : g_out
    logic [MAXRPM_W-1:0] mag_sel;
    logic [RPM_W-1:0]    mag_ext;

    assign mag_sel = side_r[DIV_STAGES-1].scale ? quo[i]
                                                : side_r[DIV_STAGES-1].unscaled[i];
    assign mag_ext = {1'b0, mag_sel};

    always_ff @(posedge clk) begin
      if (en[ST_OUT]) begin
        rpm_out_r[i] <= side_r[DIV_STAGES-1].neg[i] ? (~mag_ext + RPM_W'(1)) : mag_ext;
      end
    end
  end

  assign out_tdata = {{(OUT_TDATA_W-NUM_WHEELS*RPM_W){1'b0}},
                      rpm_out_r[3], rpm_out_r[2], rpm_out_r[1], rpm_out_r[0]};

endmodule

// ===== rtl/mwsm_divider.sv =====
// ---------------------------------------------------------------------------
// mwsm_divider
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// The quotient is known to fit MAXRPM_W bits (numerator < den * 2^MAXRPM_W).
// ---------------------------------------------------------------------------
module mwsm_divider import mwsm_pkg::*; (
  input  logic                  clk,
  input  logic [DIV_STAGES-1:0] stage_en,
  input  logic [NUM_W-1:0]      num_i,
  input  logic [MAG_W-1:0]      den_i,
  output logic [MAXRPM_W-1:0]   quo_o
);

  logic [NUM_W-1:0]    rem_r [DIV_STAGES];
  logic [MAG_W-1:0]    den_r [DIV_STAGES];
  logic [MAXRPM_W-1:0] quo_r [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    logic [NUM_W-1:0]    rem_in;
    logic [MAG_W-1:0]    den_in;
    logic [MAXRPM_W-1:0] quo_in;
    logic [NUM_W-1:0]    den_sh;
    logic [NUM_W:0]      diff;

    if (j == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign den_in = den_r[j-1];
      assign quo_in = quo_r[j-1];
    end

    assign den_sh = NUM_W'(den_in) << (DIV_STAGES - 1 - j);
    assign diff   = {1'b0, rem_in} - {1'b0, den_sh};

    always_ff @(posedge clk) begin
      if (stage_en[j]) begin
        den_r[j] <= den_in;
        if (!diff[NUM_W]) begin
          rem_r[j] <= diff[NUM_W-1:0];
          quo_r[j] <= quo_in | (MAXRPM_W'(1) << (DIV_STAGES - 1 - j));
        end else begin
          rem_r[j] <= rem_in;
          quo_r[j] <= quo_in;
        end
      end
    end
  end

  assign quo_o = quo_r[DIV_STAGES-1];

endmodule

// ===== rtl/mwsm_checker.sv =====
// ---------------------------------------------------------------------------
// mwsm_checker
// Port-level checks on the wheel mixer, bound to the top level.
// ---------------------------------------------------------------------------
`include "mecanum_wheel_speed_mixer_macros.svh"

module mwsm_checker import mwsm_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result holds its value
  `MWSM_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  // input back-pressure only comes from a stalled output
  `MWSM_ASSERT_IMP(a_in_stall_cause, !in_tready, out_tvalid && !out_tready, "input stalled without output stall")

  // pipeline empty straight after reset
  `MWSM_ASSERT_IMP(a_empty_after_rst, $past(!rst_n), !out_tvalid, "result present after reset")

  // wheel magnitudes stay within 14 bits and the padding is zero
  `MWSM_ASSERT_IMP(a_out_range, out_tvalid, (out_tdata[14:0] != 15'h4000) && (out_tdata[29:15] != 15'h4000) && (out_tdata[44:30] != 15'h4000) && (out_tdata[59:45] != 15'h4000) && (out_tdata[63:60] == 4'h0), "wheel rpm out of range")

endmodule

bind mecanum_wheel_speed_mixer mwsm_checker u_mwsm_checker (.*);
